>>> design/ed_pkg.sv
// Shared types, constants and helpers for the edit distance block.
// No dependencies; every other file imports this package.
package ed_pkg;

  localparam int MAX_LEN = 128;
  localparam int LEN_W   = $clog2(MAX_LEN + 1);
  localparam int ADDR_W  = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int DIST_W  = 8;

  localparam logic [1:0] OP_FIRST  = 2'd0;
  localparam logic [1:0] OP_SECOND = 2'd1;
  localparam logic [1:0] OP_FINISH = 2'd2;

  typedef enum logic {
    ST_LOAD,
    ST_RUN
  } ed_state_t;

  // one row of the cost matrix moving right along the cell chain
  typedef struct packed {
    logic             valid;
    logic             last;
    logic [7:0]       ch;
    logic [LEN_W-1:0] val;
  } ed_link_t;

  // controls broadcast to every cell
  typedef struct packed {
    logic             wr_en;
    logic [LEN_W-1:0] wr_idx;
    logic [7:0]       wr_ch;
    logic             start;
    logic [LEN_W-1:0] lb;
  } ed_bcast_t;

  function automatic logic [DIST_W-1:0] sat_dist(input logic [LEN_W-1:0] v);
    logic [LEN_W+DIST_W-1:0] w;
    w = {{DIST_W{1'b0}}, v};
    if (w > (LEN_W + DIST_W)'(2 ** DIST_W - 1)) begin
      return {DIST_W{1'b1}};
    end
    return w[DIST_W-1:0];
  endfunction

endpackage

>>> design/ed_cell.sv
// One column of the cost matrix: holds one byte of the second string.
// Depends on ed_pkg.
module ed_cell (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic [ed_pkg::LEN_W-1:0] cell_idx,
  input  ed_pkg::ed_bcast_t      bcast,
  input  ed_pkg::ed_link_t       link_in,
  output ed_pkg::ed_link_t       link_out
);
  import ed_pkg::*;

  logic [7:0]       b_r;
  logic             en_r;
  logic [LEN_W-1:0] up_r;
  logic [LEN_W-1:0] diag_r;
  ed_link_t         out_r;
  logic [LEN_W-1:0] m1;
  logic [LEN_W-1:0] m2;
  logic [LEN_W-1:0] val_nxt;

  always_comb begin
    m1 = (diag_r < link_in.val) ? diag_r : link_in.val;
    m2 = (m1 < up_r) ? m1 : up_r;
    if (!en_r) begin
      val_nxt = link_in.val;
    end else if (link_in.ch == b_r) begin
      val_nxt = diag_r;
    end else begin
      val_nxt = m2 + LEN_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_r.valid <= 1'b0;
    end else begin
      out_r.valid <= link_in.valid;
    end
    if (bcast.wr_en && bcast.wr_idx == cell_idx) begin
      b_r <= bcast.wr_ch;
    end
    if (bcast.start) begin
      en_r   <= (cell_idx <= bcast.lb);
      up_r   <= cell_idx;
      diag_r <= cell_idx - LEN_W'(1);
    end else if (link_in.valid) begin
      up_r   <= val_nxt;
      diag_r <= link_in.val;
    end
    out_r.last <= link_in.last;
    out_r.ch   <= link_in.ch;
    out_r.val  <= val_nxt;
  end

  assign link_out = out_r;

endmodule

>>> design/ed_ctrl.sv
// Stream control: first string memory, lengths, row feeder and result register.
// Depends on ed_pkg.
module ed_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [7:0]        in_tdata,   // [7:0] ch
  input  logic [1:0]        in_tuser,   // [1:0] op
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [7:0]        out_tdata,  // [7:0] distance
  output logic [0:0]        out_tuser,  // [0] overflow
  output ed_pkg::ed_bcast_t bcast,
  output ed_pkg::ed_link_t  feed,
  input  ed_pkg::ed_link_t  tail
);
  import ed_pkg::*;

  ed_state_t        state_r;
  ed_state_t        state_nxt;
  logic [7:0]       mem [MAX_LEN];
  logic [LEN_W-1:0] la_r;
  logic [LEN_W-1:0] lb_r;
  logic             drop_r;
  logic [LEN_W-1:0] rd_cnt_r;
  logic             feed_valid_r;
  logic             feed_last_r;
  logic [LEN_W-1:0] feed_row_r;
  logic [7:0]       rdata_r;
  logic             out_valid_r;
  logic [7:0]       dist_r;
  logic             ovf_r;
  logic             accept;
  logic             la_full;
  logic             lb_full;
  logic             feeding;
  logic             done;

  assign la_full = (la_r == LEN_W'(MAX_LEN));
  assign lb_full = (lb_r == LEN_W'(MAX_LEN));
  assign in_tready = (state_r == ST_LOAD) && (!out_valid_r || in_tuser != OP_FINISH);
  assign accept  = in_tvalid && in_tready;
  assign feeding = (state_r == ST_RUN) && (rd_cnt_r < la_r);
  assign done    = (state_r == ST_RUN) && tail.valid && tail.last;

  always_comb begin
    state_nxt    = state_r;
    bcast.wr_en  = accept && in_tuser == OP_SECOND && !lb_full;
    bcast.wr_idx = lb_r + LEN_W'(1);
    bcast.wr_ch  = in_tdata;
    bcast.start  = accept && in_tuser == OP_FINISH && la_r != '0;
    bcast.lb     = lb_r;
    case (state_r)
      ST_LOAD: begin
        if (bcast.start) begin
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        if (done) begin
          state_nxt = ST_LOAD;
        end
      end
      default: state_nxt = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && in_tuser == OP_FIRST && !la_full) begin
      mem[la_r[ADDR_W-1:0]] <= in_tdata;
    end
    if (feeding) begin
      rdata_r <= mem[rd_cnt_r[ADDR_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      la_r         <= '0;
      lb_r         <= '0;
      drop_r       <= 1'b0;
      rd_cnt_r     <= '0;
      feed_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      feed_valid_r <= feeding;
      if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (accept) begin
        case (in_tuser)
          OP_FIRST: begin
            if (la_full) drop_r <= 1'b1;
            else         la_r   <= la_r + LEN_W'(1);
          end
          OP_SECOND: begin
            if (lb_full) drop_r <= 1'b1;
            else         lb_r   <= lb_r + LEN_W'(1);
          end
          OP_FINISH: begin
            rd_cnt_r <= '0;
            if (la_r == '0) begin
              out_valid_r <= 1'b1;
              dist_r      <= sat_dist(lb_r);
              ovf_r       <= drop_r;
              lb_r        <= '0;
              drop_r      <= 1'b0;
            end
          end
          default: ;
        endcase
      end
      if (feeding) begin
        rd_cnt_r    <= rd_cnt_r + LEN_W'(1);
        feed_row_r  <= rd_cnt_r + LEN_W'(1);
        feed_last_r <= (rd_cnt_r + LEN_W'(1) == la_r);
      end
      if (done) begin
        out_valid_r <= 1'b1;
        dist_r      <= sat_dist(tail.val);
        ovf_r       <= drop_r;
        la_r        <= '0;
        lb_r        <= '0;
        drop_r      <= 1'b0;
      end
    end
  end

  assign feed.valid   = feed_valid_r;
  assign feed.last    = feed_last_r;
  assign feed.ch      = rdata_r;
  assign feed.val     = feed_row_r;
  assign out_tvalid   = out_valid_r;
  assign out_tdata    = dist_r;
  assign out_tuser[0] = ovf_r;

endmodule

>>> design/edit_distance.sv
// Levenshtein edit distance between two byte strings of up to MAX_LEN bytes each.
// Appends (op 0 first string, op 1 second string) are accepted even while a
// result waits. A finish with an empty first string answers the next cycle;
// otherwise the rows of the first string are read from its memory one per cycle
// into a chain of MAX_LEN cells, each holding one byte of the second string,
// and the result is taken from the end of the chain. No input is taken during
// that walk. Bytes past MAX_LEN are dropped and flagged in out_tuser.
// Depends on ed_pkg, ed_cell and ed_ctrl.
module edit_distance (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] ch
  input  logic [1:0] in_tuser,   // [1:0] op
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] distance
  output logic [0:0] out_tuser   // [0] overflow
);
  import ed_pkg::*;

  ed_bcast_t bcast;
  ed_link_t  link [MAX_LEN+1];

  ed_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .bcast      (bcast),
    .feed       (link[0]),
    .tail       (link[MAX_LEN])
  );

  for (genvar g = 0; g < MAX_LEN; g++) begin : g_cell
    ed_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cell_idx (LEN_W'(g + 1)),
      .bcast    (bcast),
      .link_in  (link[g]),
      .link_out (link[g+1])
    );
  end

  // a result from the chain never lands on a pending one
  a_no_clobber: assert property (@(posedge clk) disable iff (!rst_n)
    (link[MAX_LEN].valid && link[MAX_LEN].last) |-> !out_tvalid)
    else $error("chain result while output pending");

  // no input transfer while rows are in flight
  a_busy_feed: assert property (@(posedge clk) disable iff (!rst_n)
    (link[0].valid || link[MAX_LEN].valid) |-> !in_tready)
    else $error("input accepted during distance walk");

  // cells are initialized only from the load phase
  a_start_once: assert property (@(posedge clk) disable iff (!rst_n)
    bcast.start |=> !bcast.start && !in_tready)
    else $error("start not followed by busy");

endmodule
